// File: src/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pcss_pkg.sv
// Package for the class scan sequencer: payload types, codes and constants.
package pcss_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  bus_number;
        logic [4:0]  device_number;
        logic [2:0]  function_number;
        logic [7:0]  register_offset;
        logic [15:0] vendor_word;
        logic [15:0] device_word;
        logic [7:0]  header_kind;
        logic [7:0]  programming_interface;
    } t_out_item;

    // Input actions
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_RESPONSE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_REQUEST   = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CLASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUBCLASS = 2'd1;

    // Phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_VENDOR  = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_CLASS   = 3'd3;
    localparam logic [2:0] PH_GET_HDR = 3'd4;
    localparam logic [2:0] PH_GET_PIF = 3'd5;
    localparam logic [2:0] PH_GET_VEN = 3'd6;
    localparam logic [2:0] PH_GET_DEV = 3'd7;

    // Configuration space offsets
    localparam logic [7:0] OFF_ID     = 8'h00;
    localparam logic [7:0] OFF_CLASS  = 8'h08;
    localparam logic [7:0] OFF_HEADER = 8'h0C;

    localparam logic [15:0] NO_VENDOR   = 16'hFFFF;
    localparam int unsigned MULTI_BIT   = 7;
    localparam logic [7:0]  LAST_BUS    = 8'd255;
    localparam logic [4:0]  LAST_DEVICE = 5'd31;
    localparam logic [3:0]  ONE_FUNC    = 4'd1;
    localparam logic [3:0]  MANY_FUNCS  = 4'd8;

endpackage

// File: src/pci_class_scan_sequencer_top.sv
// Class scan sequencer: walks buses and devices, issuing config reads.
// Each item passes through an input register and then a result register.
// Throughput: one item per cycle while results are taken; the scan state updates as an item moves to the result.
// The overall pace is set by the round trip of each config read through the caller.
// Reset (synchronous, active low) clears phase to idle, the scan position, the captured
// header/interface/vendor fields, the target class/subclass and both valid flags.
`include "assert_macros.svh"

module pci_class_scan_sequencer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pcss_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pcss_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);
    import pcss_pkg::*;

    logic [7:0]  r_target_class;
    logic [7:0]  r_target_subclass;
    logic [2:0]  r_phase,    n_phase;
    logic [7:0]  r_bus,      n_bus;
    logic [4:0]  r_dev,      n_dev;
    logic [2:0]  r_fn,       n_fn;
    logic [3:0]  r_fn_limit, n_fn_limit;
    logic [7:0]  r_hdr,      n_hdr;
    logic [7:0]  r_pif,      n_pif;
    logic [15:0] r_ven,      n_ven;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        w_adv;
    logic        w_next_dev;
    logic [1:0]  w_status;
    logic [7:0]  w_offset;
    logic [31:0] w_data;
    t_out_item   w_res;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;
    assign w_data      = r_in_item.read_data;

    always_comb begin
        n_phase    = r_phase;
        n_bus      = r_bus;
        n_dev      = r_dev;
        n_fn       = r_fn;
        n_fn_limit = r_fn_limit;
        n_hdr      = r_hdr;
        n_pif      = r_pif;
        n_ven      = r_ven;
        w_next_dev = 1'b0;
        w_status   = ST_REQUEST;
        w_offset   = OFF_ID;

        if (r_in_item.action == ACT_START) begin
            n_bus      = '0;
            n_dev      = '0;
            n_fn       = '0;
            n_fn_limit = ONE_FUNC;
            n_phase    = PH_VENDOR;
            w_offset   = OFF_ID;
        end else begin
            unique case (r_phase)
                PH_VENDOR: begin
                    if (w_data[15:0] == NO_VENDOR) begin
                        w_next_dev = 1'b1;
                    end else begin
                        n_phase  = PH_HEADER;
                        w_offset = OFF_HEADER;
                    end
                end
                PH_HEADER: begin
                    n_fn_limit = w_data[16 + MULTI_BIT] ? MANY_FUNCS : ONE_FUNC;
                    n_fn       = '0;
                    n_phase    = PH_CLASS;
                    w_offset   = OFF_CLASS;
                end
                PH_CLASS: begin
                    if (w_data[31:16] == {r_target_class, r_target_subclass}) begin
                        n_phase  = PH_GET_HDR;
                        w_offset = OFF_HEADER;
                    end else if (({1'b0, r_fn} + 4'd1) < r_fn_limit) begin
                        n_fn     = r_fn + 3'd1;
                        n_phase  = PH_CLASS;
                        w_offset = OFF_CLASS;
                    end else begin
                        w_next_dev = 1'b1;
                    end
                end
                PH_GET_HDR: begin
                    n_hdr    = w_data[23:16];
                    n_phase  = PH_GET_PIF;
                    w_offset = OFF_CLASS;
                end
                PH_GET_PIF: begin
                    n_pif    = w_data[15:8];
                    n_phase  = PH_GET_VEN;
                    w_offset = OFF_ID;
                end
                PH_GET_VEN: begin
                    n_ven    = w_data[15:0];
                    n_phase  = PH_GET_DEV;
                    w_offset = OFF_ID;
                end
                PH_GET_DEV: begin
                    n_phase  = PH_IDLE;
                    w_status = ST_FOUND;
                end
                default: begin
                    w_status = ST_IGNORED;
                end
            endcase

            // Advance to the next slot, or end the walk
            if (w_next_dev) begin
                if (r_dev < LAST_DEVICE) begin
                    n_dev = r_dev + 5'd1;
                end else if (r_bus < LAST_BUS) begin
                    n_bus = r_bus + 8'd1;
                    n_dev = '0;
                end else begin
                    n_phase  = PH_IDLE;
                    w_status = ST_NOT_FOUND;
                end
                if (w_status == ST_REQUEST) begin
                    n_fn       = '0;
                    n_fn_limit = ONE_FUNC;
                    n_phase    = PH_VENDOR;
                    w_offset   = OFF_ID;
                end
            end
        end

        w_res = '0;
        w_res.status = w_status;
        unique case (w_status)
            ST_REQUEST: begin
                w_res.bus_number      = n_bus;
                w_res.device_number   = n_dev;
                w_res.function_number = n_fn;
                w_res.register_offset = w_offset;
            end
            ST_FOUND: begin
                w_res.bus_number            = r_bus;
                w_res.device_number         = r_dev;
                w_res.function_number       = r_fn;
                w_res.vendor_word           = r_ven;
                w_res.device_word           = w_data[31:16];
                w_res.header_kind           = r_hdr;
                w_res.programming_interface = r_pif;
            end
            default: begin
                w_res.status = w_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_target_class    <= '0;
            r_target_subclass <= '0;
            r_phase           <= PH_IDLE;
            r_bus             <= '0;
            r_dev             <= '0;
            r_fn              <= '0;
            r_fn_limit        <= ONE_FUNC;
            r_hdr             <= '0;
            r_pif             <= '0;
            r_ven             <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_bus       <= n_bus;
                r_dev       <= n_dev;
                r_fn        <= n_fn;
                r_fn_limit  <= n_fn_limit;
                r_hdr       <= n_hdr;
                r_pif       <= n_pif;
                r_ven       <= n_ven;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_TARGET_CLASS) begin
                    r_target_class <= i_cfg_data;
                end else if (i_cfg_index == CFG_TARGET_SUBCLASS) begin
                    r_target_subclass <= i_cfg_data;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_adv) begin
            r_out_item <= w_res;
        end
    end

    `ASSERT_NEXT(a_final_goes_idle, i_clk, i_rst_n, w_adv && (w_res.status != ST_REQUEST), r_phase == PH_IDLE, "scan not idle after final result")
    `ASSERT_IMPLY(a_found_no_offset, i_clk, i_rst_n, r_out_valid && (r_out_item.status == ST_FOUND), r_out_item.register_offset == OFF_ID, "found result carries an offset")
    `ASSERT_IMPLY(a_req_aligned, i_clk, i_rst_n, r_out_valid && (r_out_item.status == ST_REQUEST), r_out_item.register_offset[1:0] == 2'b00, "read request offset not dword aligned")
    `ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid, "held input item was lost")

endmodule
